// ----- sv/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: parse phases, header constants
// and the result record shared by the parser, the output stage and the top level.
// Depends on nothing.
package wsd_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 64;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  localparam logic [6:0] LEN_CODE_16  = 7'h7E;
  localparam logic [6:0] LEN_CODE_64  = 7'h7F;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;
  localparam logic [3:0] OP_CTRL_LO   = 4'd8;
  localparam logic [3:0] OP_CTRL_HI   = 4'd10;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] message_opcode;
    logic       end_of_message;
    logic       frame_error;
  } result_t;

endpackage

// ----- sv/wsd_in_stage.sv -----
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on nothing outside this file.
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // The held byte moves on whenever the output side can take a transaction.
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ----- sv/wsd_parser.sv -----
// Frame parser of the deframer: the parse state and the one-step update that
// turns one stream byte into at most one result. Depends on wsd_pkg.
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  phase_t                 phase, phase_next;
  logic                   final_flag, final_flag_next;
  logic                   masked_flag, masked_flag_next;
  logic                   in_message, in_message_next;
  logic [3:0]             held_opcode, held_opcode_next;
  logic [3:0]             ext_bytes_left, ext_bytes_left_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [2:0]             key_bytes_left, key_bytes_left_next;
  logic [1:0]             key_index, key_index_next;
  logic                   frame_control, frame_control_next;

  logic [LENGTH_BITS-1:0] pl_new;
  logic [LENGTH_BITS-1:0] pl_dec;
  logic [3:0]             ext_dec;
  logic [2:0]             key_dec;
  logic [6:0]             len_code;
  logic [3:0]             op;
  logic [7:0]             key_byte;
  logic                   after_len;
  logic                   start_payload;

  assign op       = rx_byte[3:0];
  assign len_code = rx_byte[6:0];
  assign pl_dec   = payload_left - LENGTH_BITS'(payload_left != '0);
  assign ext_dec  = ext_bytes_left - 4'(ext_bytes_left != 4'd0);
  assign key_dec  = key_bytes_left - 3'(key_bytes_left != 3'd0);

  // Key bytes are used most significant first.
  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next          = phase;
    final_flag_next     = final_flag;
    masked_flag_next    = masked_flag;
    in_message_next     = in_message;
    held_opcode_next    = held_opcode;
    ext_bytes_left_next = ext_bytes_left;
    payload_left_next   = payload_left;
    mask_key_next       = mask_key;
    key_bytes_left_next = key_bytes_left;
    key_index_next      = key_index;
    frame_control_next  = frame_control;
    pl_new              = payload_left;
    after_len           = 1'b0;
    start_payload       = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;
    res.message_opcode  = held_opcode;

    case (phase)
      PH_HDR0: begin
        final_flag_next    = rx_byte[7];
        frame_control_next = op inside {[OP_CTRL_LO:OP_CTRL_HI]};
        if (!in_message) begin
          held_opcode_next = op;
          in_message_next  = 1'b1;
        end
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        masked_flag_next = rx_byte[7];
        if (frame_control && len_code >= LEN_CODE_16) begin
          res_valid       = 1'b1;
          res.frame_error = 1'b1;
          in_message_next = 1'b0;
          phase_next      = PH_HDR0;
        end else if (len_code == LEN_CODE_16) begin
          payload_left_next   = '0;
          ext_bytes_left_next = EXT_BYTES_16;
          phase_next          = PH_EXT;
        end else if (len_code == LEN_CODE_64) begin
          payload_left_next   = '0;
          ext_bytes_left_next = EXT_BYTES_64;
          phase_next          = PH_EXT;
        end else begin
          pl_new            = LENGTH_BITS'(len_code);
          payload_left_next = pl_new;
          after_len         = 1'b1;
        end
      end
      PH_EXT: begin
        // Bits shifted out above the length register are dropped.
        pl_new              = {payload_left[LENGTH_BITS-9:0], rx_byte};
        payload_left_next   = pl_new;
        ext_bytes_left_next = ext_dec;
        after_len           = (ext_dec == 4'd0);
      end
      PH_KEY: begin
        mask_key_next       = {mask_key[23:0], rx_byte};
        key_bytes_left_next = key_dec;
        start_payload       = (key_dec == 3'd0);
      end
      PH_DATA: begin
        payload_left_next  = pl_dec;
        key_index_next     = key_index + 2'd1;
        res_valid          = 1'b1;
        res.has_byte       = 1'b1;
        res.payload_byte   = masked_flag ? (rx_byte ^ key_byte) : rx_byte;
        if (pl_dec == '0) begin
          res.end_of_message = final_flag;
          phase_next         = PH_HDR0;
          if (final_flag) begin
            in_message_next = 1'b0;
          end
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (after_len) begin
      if (masked_flag_next) begin
        mask_key_next       = '0;
        key_bytes_left_next = KEY_BYTES;
        phase_next          = PH_KEY;
      end else begin
        start_payload = 1'b1;
      end
    end

    // An empty final frame still closes the message with a byteless result.
    if (start_payload) begin
      key_index_next = 2'd0;
      if (pl_new != '0) begin
        phase_next = PH_DATA;
      end else begin
        phase_next = PH_HDR0;
        if (final_flag) begin
          res_valid          = 1'b1;
          res.end_of_message = 1'b1;
          in_message_next    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      final_flag     <= 1'b0;
      masked_flag    <= 1'b0;
      in_message     <= 1'b0;
      held_opcode    <= 4'd0;
      ext_bytes_left <= 4'd0;
      payload_left   <= '0;
      mask_key       <= '0;
      key_bytes_left <= 3'd0;
      key_index      <= 2'd0;
      frame_control  <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      final_flag     <= final_flag_next;
      masked_flag    <= masked_flag_next;
      in_message     <= in_message_next;
      held_opcode    <= held_opcode_next;
      ext_bytes_left <= ext_bytes_left_next;
      payload_left   <= payload_left_next;
      mask_key       <= mask_key_next;
      key_bytes_left <= key_bytes_left_next;
      key_index      <= key_index_next;
      frame_control  <= frame_control_next;
    end
  end

endmodule

// ----- sv/wsd_out_stage.sv -----
// Result register of the deframer: holds one result transaction until the
// receiver takes it. Depends on wsd_pkg.
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  wsd_pkg::result_t load_res,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_res
);
  import wsd_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

// ----- sv/websocket_frame_deframer_unit.sv -----
// WebSocket frame deframer: one stream byte per transaction in, at most one
// payload, end-of-message or error result per byte out.
// A byte is held in the input register, parsed combinationally, and its result is held in the result register.
// Throughput: one byte per cycle while out_stall is low; the only per-byte work is the parser's state
// update, which includes one LENGTH_BITS-wide decrement and zero compare.
// Reset (synchronous): both stages empty, parser waiting for a frame header.
module websocket_frame_deframer_unit #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic [3:0] message_opcode,
  output logic       end_of_message,
  output logic       frame_error
);
  import wsd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_ready;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign step = held_valid && out_ready;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (out_ready),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (step && res_valid),
    .load_res   (res),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign payload_byte   = out_res.payload_byte;
  assign has_byte       = out_res.has_byte;
  assign message_opcode = out_res.message_opcode;
  assign end_of_message = out_res.end_of_message;
  assign frame_error    = out_res.frame_error;

  // The input side only stalls while a byte is held and the result register is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (!has_byte && !end_of_message))
    else $error("error result carries data or end of message");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (payload_byte == 8'd0 && (end_of_message || frame_error)))
    else $error("byteless result is neither end marker nor error");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid) |=> out_valid)
    else $error("parser result was not captured");

endmodule
